// ===== src/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and constants shared by the MAC learning table blocks.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 4;
    localparam int AGE_W   = 8;
    localparam int COUNT_W = 9;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]        op;
        logic [MAC_W-1:0]  mac_addr;
        logic [PORT_W-1:0] port_in;
    } mlt_req_t;

    typedef struct packed {
        logic               hit;
        logic [PORT_W-1:0]  port_out;
        logic               table_full;
        logic [COUNT_W-1:0] removed_count;
    } mlt_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [AGE_W-1:0]  age;
    } mlt_entry_t;

endpackage

// ===== src/mlt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// mlt_entry_ram
// Simple dual-port entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlt_entry_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  mlt_pkg::mlt_entry_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output mlt_pkg::mlt_entry_t rd_data
);

    mlt_pkg::mlt_entry_t mem [DEPTH];
    mlt_pkg::mlt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mac_learning_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging
// MAC address to port table with learning, lookup and tick-driven aging.
// ----------------------------------------------------------------------------
// Every lookup, learn or tick sweeps the whole entry memory through its single
// read port, one entry per cycle, before the next request is accepted; an
// unused op code or a learn with an out-of-range port skips the sweep and goes
// straight to the response. Ticks write aged entries back on the write port
// behind the read. After reset the block runs a clearing pass over every entry
// of the memory and holds req_ready low meanwhile; age_limit writes are taken
// at any time. A finished response waits in an output register, so the next
// request is accepted while it is still pending.
module mac_learning_table_with_aging #(
    parameter int TABLE_SIZE = 256,
    parameter int NUM_PORTS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              req_valid,
    output logic              req_ready,
    input  mlt_pkg::mlt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mlt_pkg::mlt_rsp_t rsp
);

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_SIZE - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic                              rvalid_reg, rvalid_next;
    logic [AW-1:0]                     ridx_reg, ridx_next;
    logic [mlt_pkg::AGE_W-1:0]         age_limit_reg;
    mlt_pkg::mlt_req_t                 req_reg;
    logic                              found_reg, found_next;
    logic [AW-1:0]                     found_idx_reg, found_idx_next;
    logic [mlt_pkg::PORT_W-1:0]        found_port_reg, found_port_next;
    logic                              free_reg, free_next;
    logic [AW-1:0]                     free_idx_reg, free_idx_next;
    logic [mlt_pkg::COUNT_W-1:0]       removed_reg, removed_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    mlt_pkg::mlt_rsp_t                 rsp_reg, rsp_next;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    mlt_pkg::mlt_entry_t rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    mlt_pkg::mlt_entry_t wr_data;

    logic                      req_fire;
    logic                      is_lookup, is_learn, is_tick, learn_ok;
    logic                      port_ok;
    logic                      out_free;
    logic [mlt_pkg::AGE_W-1:0] age_inc;

    mlt_entry_ram #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign port_ok   = (32'(req.port_in) < 32'(NUM_PORTS));
    assign is_lookup = (req_reg.op == mlt_pkg::OP_LOOKUP);
    assign is_tick   = (req_reg.op == mlt_pkg::OP_TICK);
    assign is_learn  = (req_reg.op == mlt_pkg::OP_LEARN);
    // bad-port learns skip SCAN and reach DONE without a write, see accept logic
    assign learn_ok  = is_learn && (32'(req_reg.port_in) < 32'(NUM_PORTS));

    assign age_inc = (rd_data.age == mlt_pkg::AGE_MAX) ? mlt_pkg::AGE_MAX
                                                        : rd_data.age + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rvalid_next     = 1'b0;
        ridx_next       = ridx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_port_next = found_port_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        wr_data         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    free_next    = 1'b0;
                    removed_next = '0;
                    if ((req.op == mlt_pkg::OP_LOOKUP) || (req.op == mlt_pkg::OP_TICK) ||
                        ((req.op == mlt_pkg::OP_LEARN) && port_ok))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    rd_en       = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = cnt_reg[AW-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rvalid_reg)
                begin
                    state_next = ST_DONE;
                end
                if (rvalid_reg)
                begin
                    if (is_tick)
                    begin
                        // age write-back trails the read by one entry
                        if (rd_data.valid)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = ridx_reg;
                            wr_data = rd_data;
                            if (age_inc >= age_limit_reg)
                            begin
                                wr_data.valid = 1'b0;
                                if (removed_reg != mlt_pkg::COUNT_MAX)
                                begin
                                    removed_next = removed_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                wr_data.age = age_inc;
                            end
                        end
                    end
                    else
                    begin
                        if (rd_data.valid && (rd_data.mac == req_reg.mac_addr) && !found_reg)
                        begin
                            found_next      = 1'b1;
                            found_idx_next  = ridx_reg;
                            found_port_next = rd_data.port;
                        end
                        if (!rd_data.valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = ridx_reg;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next               = '0;
                    state_next             = ST_IDLE;
                    if (is_lookup || learn_ok)
                    begin
                        rsp_next.hit      = found_reg;
                        rsp_next.port_out = found_reg ? found_port_reg : '0;
                    end
                    if (learn_ok)
                    begin
                        rsp_next.table_full = !found_reg && !free_reg;
                        wr_en   = found_reg || free_reg;
                        wr_addr = found_reg ? found_idx_reg : free_idx_reg;
                        wr_data.valid = 1'b1;
                        wr_data.mac   = req_reg.mac_addr;
                        wr_data.port  = req_reg.port_in;
                        wr_data.age   = '0;
                    end
                    if (is_tick)
                    begin
                        rsp_next.removed_count = removed_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            age_limit_reg <= 8'd30;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rvalid_reg    <= rvalid_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            removed_reg   <= removed_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        ridx_reg       <= ridx_next;
        found_idx_reg  <= found_idx_next;
        found_port_reg <= found_port_next;
        free_idx_reg   <= free_idx_next;
        rsp_reg        <= rsp_next;
    end

    // write-back must never land on the entry being read in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("entry write collides with read");

    // a response carries at most one kind of result
    a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.table_full) &&
                      ((rsp.removed_count == '0) || (!rsp.hit && !rsp.table_full)))
        else $error("response mixes result kinds");

    // sweep counter stays within the table
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("sweep counter out of range");

    // no request taken before the clearing pass ends
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_ready && !rsp_valid)
        else $error("activity during clearing pass");

    // a new response is only loaded once the previous one has left
    a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp))
        else $error("pending response overwritten");

endmodule
